// ===== design/ssq_pkg.sv =====
// shared types and constants for the stable sorted priority queue
// no dependencies; every other file depends on this package
package ssq_pkg;

    localparam int CAPACITY  = 16;
    localparam int URG_W     = 3;
    localparam int NUM_BKT   = 1 << URG_W;
    localparam int PTR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int ADDR_W    = URG_W + PTR_W;
    localparam int NUM_SLOTS = NUM_BKT << PTR_W;
    localparam int TAG_W     = 8;
    localparam int LEN_W     = 8;
    localparam int COUNT_W   = 5;

    typedef enum logic {
        FN_PUSH = 1'b0,
        FN_POP  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DONE
    } t_state;

    typedef struct packed {
        t_func              func;
        logic [TAG_W-1:0]   job_tag;
        logic [URG_W-1:0]   urgency;
        logic [LEN_W-1:0]   run_length;
    } t_cmd;

    typedef struct packed {
        logic [TAG_W-1:0]   front_tag;
        logic [URG_W-1:0]   front_urgency;
        logic [LEN_W-1:0]   front_length;
        logic [TAG_W-1:0]   rear_tag;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
        logic               is_full;
        t_status            status;
    } t_rsp;

    // one stored slot; urgency is implied by the bucket it lives in
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [LEN_W-1:0]   length;
    } t_slot;

    typedef struct packed {
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        t_status            status;
        logic [ADDR_W-1:0]  front_addr;
        logic [ADDR_W-1:0]  rear_addr;
        logic [URG_W-1:0]   front_urg;
        logic [CNT_W-1:0]   occ;
        logic               empty;
        logic               full;
    } t_bkt_info;

endpackage

// ===== design/ssq_if.sv =====
// valid/ready channel interfaces for command and response beats
// depends on ssq_pkg for the payload structs
interface ssq_cmd_if;
    logic          valid;
    logic          ready;
    ssq_pkg::t_cmd data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ssq_rsp_if;
    logic          valid;
    logic          ready;
    ssq_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/ssq_ram.sv =====
// slot memory: one write port, two registered read ports
// depends on ssq_pkg
module ssq_ram (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [ssq_pkg::ADDR_W-1:0] i_wr_addr,
    input  ssq_pkg::t_slot        i_wr_data,
    input  logic                  i_rd_en,
    input  logic [ssq_pkg::ADDR_W-1:0] i_rd_addr_a,
    input  logic [ssq_pkg::ADDR_W-1:0] i_rd_addr_b,
    output ssq_pkg::t_slot        o_rd_data_a,
    output ssq_pkg::t_slot        o_rd_data_b
);
    import ssq_pkg::*;

    t_slot r_mem [NUM_SLOTS];
    t_slot r_rd_a;
    t_slot r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== design/ssq_bucket.sv =====
// per-urgency ring pointers and counts, front/rear bucket select
// depends on ssq_pkg
module ssq_bucket (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_apply,
    input  ssq_pkg::t_func            i_func,
    input  logic [ssq_pkg::URG_W-1:0] i_urgency,
    output ssq_pkg::t_bkt_info        o_info
);
    import ssq_pkg::*;

    logic [PTR_W-1:0] r_head [NUM_BKT];
    logic [PTR_W-1:0] n_head [NUM_BKT];
    logic [CNT_W-1:0] r_cnt  [NUM_BKT];
    logic [CNT_W-1:0] n_cnt  [NUM_BKT];
    logic [CNT_W-1:0] r_occ;
    logic [CNT_W-1:0] n_occ;

    logic [NUM_BKT-1:0] nonzero;
    logic [URG_W-1:0]   front_bkt;
    logic [URG_W-1:0]   rear_bkt;
    logic               full;
    logic               empty;
    logic [PTR_W-1:0]   push_slot;
    logic [PTR_W-1:0]   rear_slot;

    assign full  = (r_occ >= CNT_W'(CAPACITY));
    assign empty = (r_occ == '0);

    always_comb begin
        for (int b = 0; b < NUM_BKT; b++) begin
            nonzero[b] = (r_cnt[b] != '0);
        end
    end

    // lowest nonempty bucket is the front, highest is the rear
    always_comb begin
        front_bkt = '0;
        rear_bkt  = '0;
        for (int b = NUM_BKT - 1; b >= 0; b--) begin
            if (nonzero[b]) begin
                front_bkt = URG_W'(b);
            end
        end
        for (int b = 0; b < NUM_BKT; b++) begin
            if (nonzero[b]) begin
                rear_bkt = URG_W'(b);
            end
        end
    end

    assign push_slot = r_head[i_urgency] + r_cnt[i_urgency][PTR_W-1:0];
    assign rear_slot = r_head[rear_bkt] + r_cnt[rear_bkt][PTR_W-1:0] - PTR_W'(1);

    always_comb begin
        n_head = r_head;
        n_cnt  = r_cnt;
        n_occ  = r_occ;
        if (i_apply) begin
            if (i_func == FN_PUSH) begin
                if (!full) begin
                    n_cnt[i_urgency] = r_cnt[i_urgency] + CNT_W'(1);
                    n_occ            = r_occ + CNT_W'(1);
                end
            end else if (!empty) begin
                n_head[front_bkt] = r_head[front_bkt] + PTR_W'(1);
                n_cnt[front_bkt]  = r_cnt[front_bkt] - CNT_W'(1);
                n_occ             = r_occ - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BKT; b++) begin
                r_head[b] <= '0;
                r_cnt[b]  <= '0;
            end
            r_occ <= '0;
        end else begin
            r_head <= n_head;
            r_cnt  <= n_cnt;
            r_occ  <= n_occ;
        end
    end

    always_comb begin
        o_info.wr_en      = i_apply && (i_func == FN_PUSH) && !full;
        o_info.wr_addr    = {i_urgency, push_slot};
        if ((i_func == FN_PUSH) && full) begin
            o_info.status = ST_PUSH_FULL;
        end else if ((i_func == FN_POP) && empty) begin
            o_info.status = ST_POP_EMPTY;
        end else begin
            o_info.status = ST_OK;
        end
        o_info.front_addr = {front_bkt, r_head[front_bkt]};
        o_info.rear_addr  = {rear_bkt, rear_slot};
        o_info.front_urg  = front_bkt;
        o_info.occ        = r_occ;
        o_info.empty      = empty;
        o_info.full       = full;
    end

endmodule

// ===== design/stable_sorted_priority_queue.sv =====
// top level: command sequencer, bucket bookkeeping, slot memory, response register
// depends on ssq_pkg, ssq_if, ssq_bucket, ssq_ram
//
//  channel  dir  payload                                   handshake
//  i_cmd    in   func, job_tag, urgency, run_length        valid/ready
//  o_rsp    out  front/rear entry, count, flags, status    valid/ready
//
// each command runs in order: bucket update and slot write, then one
// memory read of the front and rear slots, then the response register load.
// the memory has one write and two read ports.
// i_cmd is ready only between commands; a waiting response does not block
// the next command, only its final load. reset empties all buckets at once.
module stable_sorted_priority_queue (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssq_cmd_if.sink   i_cmd,
    ssq_rsp_if.source o_rsp
);
    import ssq_pkg::*;

    t_state    r_state;
    t_state    n_state;
    t_status   r_status;
    t_status   n_status;
    logic      r_out_valid;
    logic      n_out_valid;
    t_rsp      r_out;
    t_rsp      n_out;

    logic      accept;
    logic      rd_en;
    t_bkt_info info;
    t_slot     wr_data;
    t_slot     front_slot;
    t_slot     rear_slot;

    assign accept  = i_cmd.valid && i_cmd.ready;
    assign wr_data = '{tag: i_cmd.data.job_tag, length: i_cmd.data.run_length};

    ssq_bucket u_bucket (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_apply   (accept),
        .i_func    (i_cmd.data.func),
        .i_urgency (i_cmd.data.urgency),
        .o_info    (info)
    );

    ssq_ram u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (info.wr_en),
        .i_wr_addr   (info.wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_en     (rd_en),
        .i_rd_addr_a (info.front_addr),
        .i_rd_addr_b (info.rear_addr),
        .o_rd_data_a (front_slot),
        .o_rd_data_b (rear_slot)
    );

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        rd_en       = 1'b0;
        i_cmd.ready = 1'b0;

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid) begin
                    n_status = info.status;
                    n_state  = S_READ;
                end
            end
            S_READ: begin
                rd_en   = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                // load once the response register is free or being drained
                if (!r_out_valid || o_rsp.ready) begin
                    if (info.empty) begin
                        n_out.front_tag     = '0;
                        n_out.front_urgency = '0;
                        n_out.front_length  = '0;
                        n_out.rear_tag      = '0;
                    end else begin
                        n_out.front_tag     = front_slot.tag;
                        n_out.front_urgency = info.front_urg;
                        n_out.front_length  = front_slot.length;
                        n_out.rear_tag      = rear_slot.tag;
                    end
                    n_out.entry_count = COUNT_W'(info.occ);
                    n_out.is_empty    = info.empty;
                    n_out.is_full     = info.full;
                    n_out.status      = r_status;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

// ===== dv/ssq_checker.sv =====
// response checker for the stable sorted priority queue: keeps its own sorted job list,
// predicts the response of every accepted command and compares it with what comes out
// depends on ssq_pkg for the command and response structs
module ssq_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  logic           i_cmd_ready,
    input  ssq_pkg::t_cmd  i_cmd_data,
    input  logic           i_rsp_valid,
    input  logic           i_rsp_ready,
    input  ssq_pkg::t_rsp  i_rsp_data,
    output int             o_mismatches,
    output int             o_outstanding
);
    import ssq_pkg::*;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [URG_W-1:0] urg;
        logic [LEN_W-1:0] len;
    } t_job;

    t_job jobs[$];          // front of the queue at index 0
    t_rsp rsp_pending[$];   // predicted responses, oldest first
    int   mismatches = 0;
    int   outstanding = 0;

    assign o_mismatches  = mismatches;
    assign o_outstanding = outstanding;

    // applies one command to the job list and returns the response it should produce
    function automatic t_rsp apply_cmd(t_cmd c);
        t_rsp r;
        t_job j;
        int   pos;
        r = '0;
        r.status = ST_OK;
        if (c.func == FN_PUSH) begin
            if (jobs.size() >= CAPACITY) begin
                r.status = ST_PUSH_FULL;
            end else begin
                // behind every job of equal or more urgent priority
                pos = 0;
                while (pos < jobs.size() && jobs[pos].urg <= c.urgency) pos++;
                j.tag = c.job_tag;
                j.urg = c.urgency;
                j.len = c.run_length;
                jobs.insert(pos, j);
            end
        end else begin
            if (jobs.size() == 0) r.status = ST_POP_EMPTY;
            else void'(jobs.pop_front());
        end
        if (jobs.size() > 0) begin
            r.front_tag     = jobs[0].tag;
            r.front_urgency = jobs[0].urg;
            r.front_length  = jobs[0].len;
            r.rear_tag      = jobs[jobs.size()-1].tag;
        end
        r.entry_count = COUNT_W'(jobs.size());
        r.is_empty    = (jobs.size() == 0);
        r.is_full     = (jobs.size() >= CAPACITY);
        return r;
    endfunction

    function automatic string rsp_text(t_rsp r);
        return $sformatf("front %0d/%0d/%0d rear %0d count %0d empty %0b full %0b status %0d",
                         r.front_tag, r.front_urgency, r.front_length, r.rear_tag,
                         r.entry_count, r.is_empty, r.is_full, r.status);
    endfunction

    function automatic string diff_fields(t_rsp want, t_rsp got);
        string s;
        s = "";
        if (got.front_tag !== want.front_tag)         s = {s, " front_tag"};
        if (got.front_urgency !== want.front_urgency) s = {s, " front_urgency"};
        if (got.front_length !== want.front_length)   s = {s, " front_length"};
        if (got.rear_tag !== want.rear_tag)           s = {s, " rear_tag"};
        if (got.entry_count !== want.entry_count)     s = {s, " entry_count"};
        if (got.is_empty !== want.is_empty)           s = {s, " is_empty"};
        if (got.is_full !== want.is_full)             s = {s, " is_full"};
        if (got.status !== want.status)               s = {s, " status"};
        return s;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_rsp  want;
        string bad;
        if (!i_rst_n) begin
            jobs.delete();
            rsp_pending.delete();
        end else begin
            if (i_cmd_valid && i_cmd_ready) rsp_pending.push_back(apply_cmd(i_cmd_data));
            if (i_rsp_valid && i_rsp_ready) begin
                if (rsp_pending.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ssq_checker: response beat with none pending: %s",
                                 rsp_text(i_rsp_data));
                end else begin
                    want = rsp_pending.pop_front();
                    bad  = diff_fields(want, i_rsp_data);
                    if (bad != "") begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ssq_checker: mismatch in%s\n  expected %s\n  actual   %s",
                                     bad, rsp_text(want), rsp_text(i_rsp_data));
                    end
                end
            end
        end
        outstanding = rsp_pending.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// testbench top for stable_sorted_priority_queue: clock, reset, command stimulus,
// response back-pressure and the verdict; checking lives in ssq_checker
// depends on ssq_pkg, ssq_if, the design and dv/ssq_checker.sv
module tb_top;
    import ssq_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 850;
    localparam int QUIET_ITEMS  = 150;
    localparam int SEGMENT      = 40;

    logic i_clk;
    logic i_rst_n;
    logic quiet;
    int   mismatches;
    int   outstanding;
    int   cycles = 0;

    ssq_cmd_if cmd_if ();
    ssq_rsp_if rsp_if ();

    stable_sorted_priority_queue u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    ssq_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_if.valid),
        .i_cmd_ready   (cmd_if.ready),
        .i_cmd_data    (cmd_if.data),
        .i_rsp_valid   (rsp_if.valid),
        .i_rsp_ready   (rsp_if.ready),
        .i_rsp_data    (rsp_if.data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // response back-pressure: random stall bursts between ready runs
    initial begin : rsp_stall
        logic rdy;
        int   hold;
        rdy = 1'b1;
        hold = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (quiet) begin
                rdy = 1'b1;
            end else if (rdy && $urandom_range(0, 5) == 0) begin
                rdy  = 1'b0;
                hold = $urandom_range(0, 14);
            end else begin
                rdy  = 1'b1;
                hold = $urandom_range(0, 30);
            end
            rsp_if.ready <= rdy;
        end
    end

    task automatic hold_off(int n);
        cmd_if.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // one command beat; returns at the falling edge after acceptance, unless quiet sometimes after an idle gap
    task automatic send_job(t_func f, logic [TAG_W-1:0] tag, logic [URG_W-1:0] urg,
                            logic [LEN_W-1:0] len);
        t_cmd c;
        c.func       = f;
        c.job_tag    = tag;
        c.urgency    = urg;
        c.run_length = len;
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= c;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 7) == 0) hold_off($urandom_range(1, 15));
    endtask

    // sender waits until every predicted response has come back
    task automatic drain();
        cmd_if.valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int push_pct;
        quiet        = 1'b0;
        i_rst_n      = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // pop on an empty queue, extremes, ties in urgency, fill up, push on full, then pops
        send_job(FN_POP, 8'hA5, 3'd5, 8'h5A);
        send_job(FN_PUSH, 8'hFF, 3'd7, 8'hFF);
        send_job(FN_PUSH, 8'h00, 3'd0, 8'h00);
        send_job(FN_PUSH, 8'h11, 3'd3, 8'h21);
        send_job(FN_PUSH, 8'h12, 3'd3, 8'h22);
        send_job(FN_PUSH, 8'h13, 3'd3, 8'h23);
        send_job(FN_PUSH, 8'h77, 3'd7, 8'h01);
        send_job(FN_PUSH, 8'h01, 3'd0, 8'h80);
        for (int i = 0; i < 9; i++)
            send_job(FN_PUSH, 8'(8'h40 + i), 3'(7 - i), 8'(i * 29));
        send_job(FN_PUSH, 8'hEE, 3'd0, 8'h55);
        for (int i = 0; i < 6; i++)
            send_job(FN_POP, 8'(i), 3'(i), 8'(i));
        drain();

        // random part: push share changes per segment so the queue swings full and empty
        push_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % SEGMENT == 0) begin
                case ($urandom_range(0, 3))
                    0: push_pct = 15;
                    1: push_pct = 50;
                    2: push_pct = 85;
                    default: push_pct = 97;
                endcase
            end
            if (n == RANDOM_ITEMS / 2) drain();
            if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            send_job(($urandom_range(0, 99) < push_pct) ? FN_PUSH : FN_POP,
                     8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                     8'($urandom_range(0, 255)));
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
